[sv/nhe_pkg.sv]
`timescale 1ns / 1ps

package nhe_pkg;

  // Default bound on log2 of the stripe length.
  localparam int MAX_LOG2_BYTES_DEF = 9;

  // Register reset: largest stripe.
  localparam logic [3:0] LOG2_RESET = 4'd9;

  // Nibble parity table and the column masks of one byte.
  localparam logic [15:0] PARITY_LUT = 16'h6996;
  localparam logic [7:0]  COL_MASK0  = 8'h55;
  localparam logic [7:0]  COL_MASK1  = 8'h33;
  localparam logic [7:0]  COL_MASK2  = 8'h0f;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_SINGLE = 2'd1,
    STATUS_MULTI  = 2'd2
  } status_t;

  // Control from the pipeline to the accumulator.
  typedef struct packed {
    logic       fire;
    logic [3:0] log2_eff;
  } nhe_ctl_t;

  function automatic logic parity8(input logic [7:0] v);
    logic [3:0] n;
    n = v[7:4] ^ v[3:0];
    return PARITY_LUT[n];
  endfunction

  // Column parities: even bit over positions with address bit 0, odd over 1.
  function automatic logic [5:0] column_ecc(input logic [7:0] b);
    logic [5:0] r;
    r[0] = parity8(b & COL_MASK0);
    r[1] = parity8(b & ~COL_MASK0);
    r[2] = parity8(b & COL_MASK1);
    r[3] = parity8(b & ~COL_MASK1);
    r[4] = parity8(b & COL_MASK2);
    r[5] = parity8(b & ~COL_MASK2);
    return r;
  endfunction

endpackage

[sv/nhe_accum.sv]
`timescale 1ns / 1ps

module nhe_accum #(
  parameter int MAX_LOG2_BYTES = nhe_pkg::MAX_LOG2_BYTES_DEF,
  parameter int ACC_W          = 2 * (MAX_LOG2_BYTES + 3),
  parameter int CNT_W          = (MAX_LOG2_BYTES > 0) ? MAX_LOG2_BYTES : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  nhe_pkg::nhe_ctl_t     ctl,
  input  logic [7:0]            data_byte,
  output logic [ACC_W-1:0]      acc_next,
  output logic                  is_last
);

  logic [CNT_W-1:0] byte_count;
  logic [ACC_W-1:0] ecc_accumulator;
  logic [CNT_W-1:0] last_index;
  logic             row_par;

  always_comb begin
    for (int i = 0; i < CNT_W; i++) begin
      last_index[i] = (i < int'(ctl.log2_eff));
    end
    is_last = (byte_count >= last_index);
  end

  // Fold the column parities and, for an odd byte, every row pair.
  always_comb begin
    row_par  = nhe_pkg::parity8(data_byte);
    acc_next = ecc_accumulator;
    acc_next[5:0] = ecc_accumulator[5:0] ^ nhe_pkg::column_ecc(data_byte);
    for (int a = 0; a < MAX_LOG2_BYTES; a++) begin
      if (row_par) begin
        if (byte_count[a]) begin
          acc_next[2 * (a + 3) + 1] = ~ecc_accumulator[2 * (a + 3) + 1];
        end else begin
          acc_next[2 * (a + 3)] = ~ecc_accumulator[2 * (a + 3)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      ecc_accumulator <= '0;
    end else if (ctl.fire) begin
      if (is_last) begin
        byte_count      <= '0;
        ecc_accumulator <= '0;
      end else begin
        byte_count      <= byte_count + 1'b1;
        ecc_accumulator <= acc_next;
      end
    end
  end

endmodule

[sv/nhe_decode.sv]
`timescale 1ns / 1ps

module nhe_decode #(
  parameter int MAX_LOG2_BYTES = nhe_pkg::MAX_LOG2_BYTES_DEF,
  parameter int NPAIRS         = MAX_LOG2_BYTES + 3,
  parameter int ACC_W          = 2 * NPAIRS
) (
  input  logic [ACC_W-1:0]  acc,
  input  logic [23:0]       stored_ecc,
  input  logic [3:0]        log2_eff,
  output logic [23:0]       computed_ecc,
  output nhe_pkg::status_t  status,
  output logic [8:0]        error_byte,
  output logic [2:0]        error_bit
);

  logic [ACC_W-1:0]    used;
  logic [ACC_W-1:0]    comp;
  logic [ACC_W-1:0]    diff;
  logic [ACC_W+23:0]   stored_ext;
  logic [ACC_W+23:0]   comp_ext;
  logic [NPAIRS-1:0]   loc;
  logic [NPAIRS+8:0]   loc_ext;
  logic                bad;

  always_comb begin
    for (int j = 0; j < ACC_W; j++) begin
      used[j] = (j < 2 * (int'(log2_eff) + 3));
    end
    stored_ext = {{ACC_W{1'b0}}, stored_ecc};
    comp       = acc & used;
    diff       = comp ^ (stored_ext[ACC_W-1:0] & used);
    comp_ext   = {24'b0, comp};
    computed_ecc = comp_ext[23:0];
  end

  // A usable syndrome has exactly one bit set in every used pair.
  always_comb begin
    bad = 1'b0;
    for (int p = 0; p < NPAIRS; p++) begin
      loc[p] = (p < int'(log2_eff) + 3) && (diff[2 * p +: 2] == 2'b10);
      if ((p < int'(log2_eff) + 3) &&
          ((diff[2 * p +: 2] == 2'b00) || (diff[2 * p +: 2] == 2'b11))) begin
        bad = 1'b1;
      end
    end
    if (diff == '0) begin
      status = nhe_pkg::STATUS_OK;
    end else if (bad) begin
      status = nhe_pkg::STATUS_MULTI;
    end else begin
      status = nhe_pkg::STATUS_SINGLE;
    end
    loc_ext    = (status == nhe_pkg::STATUS_SINGLE) ? {9'b0, loc} : '0;
    error_byte = loc_ext[11:3];
    error_bit  = loc_ext[2:0];
  end

endmodule

[sv/nand_hamming_ecc_check_top.sv]
`timescale 1ns / 1ps

// NAND Hamming ECC checker. Feed the bytes of a stripe in address order, one
// request per byte on the in channel; the stripe holds 2^cfg_wr_data bytes
// (values above MAX_LOG2_BYTES act as the bound). The block takes one byte
// every cycle and keeps doing so while a result waits on a stalled out
// channel, until its input register is also full. The last byte of each
// stripe yields one result request through the input and result registers,
// once the result register is free: the
// computed ECC (pair p in bits 2p and 2p+1, unused pairs zero), a status of
// no error, single bit error or uncorrectable, and for a single error the
// byte index and bit to flip. Only the stored_ecc that comes with the last
// byte is used. The rate is set by the XOR update of the running parity
// accumulator. Write the size register only while no stripe is in flight.

module nand_hamming_ecc_check_top #(
  parameter int MAX_LOG2_BYTES = nhe_pkg::MAX_LOG2_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic [23:0] stored_ecc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] computed_ecc,
  output logic [1:0]  status,
  output logic [8:0]  error_byte,
  output logic [2:0]  error_bit
);

  localparam int NPAIRS = MAX_LOG2_BYTES + 3;
  localparam int ACC_W  = 2 * NPAIRS;

  // Size register, clamped to the bound.
  logic [3:0]  log2_stripe_bytes;
  logic [3:0]  log2_eff;

  // Input register.
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic [23:0] s1_stored;

  logic        s2_ready;
  logic        s1_load;

  nhe_pkg::nhe_ctl_t ctl;
  logic [ACC_W-1:0]  acc_next;
  logic              is_last;

  logic [23:0]       dec_ecc;
  nhe_pkg::status_t  dec_status;
  logic [8:0]        dec_byte;
  logic [2:0]        dec_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_stripe_bytes <= nhe_pkg::LOG2_RESET;
    end else if (cfg_wr_en) begin
      log2_stripe_bytes <= cfg_wr_data;
    end
  end

  assign log2_eff = (32'(log2_stripe_bytes) > 32'(MAX_LOG2_BYTES)) ?
                    4'(MAX_LOG2_BYTES) : log2_stripe_bytes;

  // The result stage moves when the output register is empty or being taken.
  assign s2_ready = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s2_ready;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s2_ready || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  // Hold the payload while the request waits.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_byte   <= data_byte;
      s1_stored <= stored_ecc;
    end
  end

  assign ctl.fire     = s1_valid && s2_ready;
  assign ctl.log2_eff = log2_eff;

  nhe_accum #(
    .MAX_LOG2_BYTES (MAX_LOG2_BYTES),
    .ACC_W          (ACC_W)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .data_byte (s1_byte),
    .acc_next  (acc_next),
    .is_last   (is_last)
  );

  nhe_decode #(
    .MAX_LOG2_BYTES (MAX_LOG2_BYTES),
    .NPAIRS         (NPAIRS),
    .ACC_W          (ACC_W)
  ) u_decode (
    .acc          (acc_next),
    .stored_ecc   (s1_stored),
    .log2_eff     (log2_eff),
    .computed_ecc (dec_ecc),
    .status       (dec_status),
    .error_byte   (dec_byte),
    .error_bit    (dec_bit)
  );

  // Result register: load on the last byte, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid && is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && is_last) begin
      computed_ecc <= dec_ecc;
      status       <= dec_status;
      error_byte   <= dec_byte;
      error_bit    <= dec_bit;
    end
  end

`ifndef SYNTHESIS
  // A stall is raised only for a full input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // A byte blocked at the result stage is kept.
  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_ready) |=> s1_valid)
    else $error("blocked byte lost");

  // No location is reported unless the error is single.
  a_loc_only_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != 2'(nhe_pkg::STATUS_SINGLE))) |->
      (error_byte == 9'd0 && error_bit == 3'd0))
    else $error("error location without single error");

  // Status never carries the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3))
    else $error("invalid status code");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  // Size bound of the block, taken from the package default.
  localparam int SIZE_BOUND  = nhe_pkg::MAX_LOG2_BYTES_DEF;
  // Marks a table row that leaves the size register alone.
  localparam int KEEP_SIZE   = -1;
  // Cycles without any request moving before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Length of the long receiver hold, in cycles.
  localparam int HOLD_CYCLES = 90;
  // Random part stops once this many bytes have been taken.
  localparam int BYTE_TARGET = 1450;

  typedef struct {
    logic [23:0]      ecc;
    nhe_pkg::status_t st;
    logic [8:0]       err_byte;
    logic [2:0]       err_bit;
  } ecc_report_t;

  // One directed request: optional size write first, then one byte.
  typedef struct {
    int               size_wr;
    logic [7:0]       data;
    logic [23:0]      stored;
    bit               typed;
    logic [23:0]      ecc;
    nhe_pkg::status_t st;
    logic [8:0]       err_byte;
    logic [2:0]       err_bit;
  } probe_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic [23:0] stored_ecc;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] computed_ecc;
  logic [1:0]  status;
  logic [8:0]  error_byte;
  logic [2:0]  error_bit;

  // Shadow of the block: size register, byte address within the stripe and
  // the running parity of the stripe so far.
  logic [3:0]  size_reg;
  logic [8:0]  stripe_pos;
  logic [23:0] parity_acc;

  ecc_report_t due_reports[$];
  ecc_report_t pinned_report;
  ecc_report_t seen_report;
  bit          pinned;
  int          mismatches;
  int          bytes_taken;
  int          quiet_cycles;
  bit          calm;
  bit          hold_now;
  bit          hold_done;

  // Directed requests. Single-byte stripes first (size 0), where the expected
  // report follows at a glance from the column parities alone; then the
  // two-byte stripe, the shrink in the middle of a stripe, and a single-bit
  // error in the second byte of a two-byte stripe.
  probe_t probes [18] = '{
    '{0,         8'h00, 24'h000000, 1'b1, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{KEEP_SIZE, 8'hff, 24'h000000, 1'b1, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{KEEP_SIZE, 8'h01, 24'h000015, 1'b1, 24'h000015, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{KEEP_SIZE, 8'h01, 24'h000000, 1'b1, 24'h000015, nhe_pkg::STATUS_SINGLE, 9'd0, 3'd0},
    '{KEEP_SIZE, 8'h80, 24'h000000, 1'b1, 24'h00002a, nhe_pkg::STATUS_SINGLE, 9'd0, 3'd7},
    '{KEEP_SIZE, 8'h00, 24'hffffc0, 1'b1, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{KEEP_SIZE, 8'h00, 24'h000001, 1'b1, 24'h000000, nhe_pkg::STATUS_MULTI,  9'd0, 3'd0},
    '{KEEP_SIZE, 8'h00, 24'h000003, 1'b1, 24'h000000, nhe_pkg::STATUS_MULTI,  9'd0, 3'd0},
    '{KEEP_SIZE, 8'h01, 24'hffffea, 1'b1, 24'h000015, nhe_pkg::STATUS_MULTI,  9'd0, 3'd0},
    '{KEEP_SIZE, 8'h5a, 24'h123456, 1'b0, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{1,         8'h3c, 24'h7e0f00, 1'b0, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{KEEP_SIZE, 8'hc3, 24'habcdef, 1'b0, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{2,         8'h11, 24'h000000, 1'b0, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{KEEP_SIZE, 8'h22, 24'h000000, 1'b0, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{1,         8'h44, 24'h000fff, 1'b0, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{KEEP_SIZE, 8'h00, 24'h000000, 1'b0, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0},
    '{KEEP_SIZE, 8'h04, 24'h000000, 1'b1, 24'h000099, nhe_pkg::STATUS_SINGLE, 9'd1, 3'd2},
    '{0,         8'hff, 24'hfffffe, 1'b0, 24'h000000, nhe_pkg::STATUS_OK,     9'd0, 3'd0}
  };

  nand_hamming_ecc_check_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .stored_ecc   (stored_ecc),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .computed_ecc (computed_ecc),
    .status       (status),
    .error_byte   (error_byte),
    .error_bit    (error_bit)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Fold one byte at a given stripe address into a running parity word.
  // Column pairs: even bit for positions with the address bit clear, odd bit
  // for those with it set. Row pairs: split the byte parity by each bit of
  // the byte address, over every pair the bound allows.
  function automatic logic [23:0] fold_ecc_byte(logic [23:0] acc, logic [8:0] addr,
                                                logic [7:0] b);
    logic [23:0] r;
    int i, k, a;
    r = acc;
    for (i = 0; i < 8; i++)
      if (b[i])
        for (k = 0; k < 3; k++)
          r[2 * k + ((i >> k) & 1)] ^= 1'b1;
    if (^b)
      for (a = 0; a < SIZE_BOUND; a++)
        r[2 * (a + 3) + addr[a]] ^= 1'b1;
    return r;
  endfunction

  function automatic logic [23:0] used_pairs_mask(int lg);
    return 24'((32'd1 << (2 * (lg + 3))) - 32'd1);
  endfunction

  // Compare a finished stripe's parity with the stored one and grade it. A
  // pair that differs in its odd bit only points at a set address bit, in
  // its even bit only at a clear one; any other pattern in a differing word
  // makes the stripe uncorrectable.
  function automatic ecc_report_t grade_stripe(logic [23:0] acc, logic [23:0] stored,
                                               int lg);
    ecc_report_t r;
    logic [23:0] used;
    logic [23:0] diff;
    logic [11:0] loc;
    logic [1:0]  pd;
    int p;
    used  = used_pairs_mask(lg);
    r.ecc = acc & used;
    diff  = r.ecc ^ (stored & used);
    loc   = '0;
    r.st  = nhe_pkg::STATUS_OK;
    if (diff != '0) begin
      r.st = nhe_pkg::STATUS_SINGLE;
      for (p = 0; p < lg + 3 && r.st == nhe_pkg::STATUS_SINGLE; p++) begin
        pd = diff[2 * p +: 2];
        if (pd == 2'b10) begin
          loc[p] = 1'b1;
        end else if (pd != 2'b01) begin
          r.st = nhe_pkg::STATUS_MULTI;
        end
      end
      if (r.st != nhe_pkg::STATUS_SINGLE) loc = '0;
    end
    r.err_byte = loc[11:3];
    r.err_bit  = loc[2:0];
    return r;
  endfunction

  // Absorb one taken byte request; queue a report when it closes the stripe.
  // A shrunk size closes the stripe as soon as the address reaches or passes
  // the new last index.
  function automatic void absorb_byte(logic [7:0] b, logic [23:0] stored);
    int lg;
    ecc_report_t r;
    lg = (int'(size_reg) > SIZE_BOUND) ? SIZE_BOUND : int'(size_reg);
    bytes_taken++;
    parity_acc = fold_ecc_byte(parity_acc, stripe_pos, b);
    if (int'(stripe_pos) < (1 << lg) - 1) begin
      stripe_pos++;
    end else begin
      r = grade_stripe(parity_acc, stored, lg);
      if (pinned) r = pinned_report;
      due_reports.push_back(r);
      stripe_pos = '0;
      parity_acc = '0;
    end
  endfunction

  function automatic void flag_mismatch(string what, logic [23:0] want, logic [23:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
  endfunction

  // Offer one byte request. Enter and leave on a falling edge; hold the
  // payload steady while the block stalls.
  task automatic send_byte(logic [7:0] b, logic [23:0] stored);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    stored_ecc <= stored;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_byte(b, stored);
    @(negedge clk);
  endtask

  // Drop valid and wait for every due report, then give the last bytes time
  // to clear the pipeline, since a mid-stripe byte produces nothing to wait on.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Write the size register with the block quiet; mirror it in the shadow.
  task automatic write_size(int v);
    drain_block();
    cfg_wr_data <= 4'(v);
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    size_reg     = 4'(v);
  endtask

  // Build one stripe of random content, work out the parity of the clean
  // data, then damage the data or the stored parity so that every grade
  // turns up: clean, one flipped data bit, two flipped data bits, one
  // flipped parity bit, or a stored word that is plain noise.
  task automatic send_stripe(int lg);
    logic [7:0]  data_buf [512];
    logic [23:0] good_ecc;
    logic [23:0] used;
    logic [23:0] stored;
    int n, j, kind, idx, idx2, bitpos, bitpos2;
    n        = 1 << lg;
    good_ecc = '0;
    for (j = 0; j < n; j++) begin
      data_buf[j] = 8'($urandom);
      good_ecc    = fold_ecc_byte(good_ecc, 9'(j), data_buf[j]);
    end
    used   = used_pairs_mask(lg);
    stored = good_ecc & used;
    kind   = $urandom_range(0, 99);
    if (kind < 40) begin
      idx    = $urandom_range(0, n - 1);
      bitpos = $urandom_range(0, 7);
      data_buf[idx][bitpos] ^= 1'b1;
    end else if (kind < 55) begin
      idx     = $urandom_range(0, n - 1);
      bitpos  = $urandom_range(0, 7);
      idx2    = $urandom_range(0, n - 1);
      bitpos2 = $urandom_range(0, 7);
      if (idx == idx2 && bitpos == bitpos2) bitpos2 = (bitpos + 1) % 8;
      data_buf[idx][bitpos]   ^= 1'b1;
      data_buf[idx2][bitpos2] ^= 1'b1;
    end else if (kind < 70) begin
      stored[$urandom_range(0, 2 * (lg + 3) - 1)] ^= 1'b1;
    end else if (kind < 85) begin
      stored = 24'($urandom);
    end
    // Fill the unused high pairs with noise; the block must ignore them.
    stored = stored | (24'($urandom) & ~used);
    for (j = 0; j < n; j++)
      send_byte(data_buf[j], (j == n - 1) ? stored : 24'($urandom));
  endtask

  // Receiver: random stalls, none while calm, and one long hold on request.
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_now && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 26);
        @(negedge clk);
      end
    end
  end

  // Check each report taken against the oldest one due.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        flag_mismatch("report with nothing due", 24'h0, computed_ecc);
      end else begin
        seen_report = due_reports.pop_front();
        if (computed_ecc !== seen_report.ecc)
          flag_mismatch("computed_ecc", seen_report.ecc, computed_ecc);
        if (status !== seen_report.st)
          flag_mismatch("status", 24'(seen_report.st), 24'(status));
        if (error_byte !== seen_report.err_byte)
          flag_mismatch("error_byte", 24'(seen_report.err_byte), 24'(error_byte));
        if (error_bit !== seen_report.err_bit)
          flag_mismatch("error_bit", 24'(seen_report.err_bit), 24'(error_bit));
      end
    end
  end

  // Abandon the run if no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("nand_hamming_ecc_check_top regression: fail");
      $finish;
    end
  end

  initial begin
    int i, phase, reg_val, lg, stripes, s;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    data_byte    = '0;
    stored_ecc   = '0;
    size_reg     = nhe_pkg::LOG2_RESET;
    stripe_pos   = '0;
    parity_acc   = '0;
    pinned       = 1'b0;
    mismatches   = 0;
    bytes_taken  = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    hold_now     = 1'b0;
    hold_done    = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: typed rows replace the shadow's report with their own.
    for (i = 0; i < $size(probes); i++) begin
      if (probes[i].size_wr != KEEP_SIZE) write_size(probes[i].size_wr);
      pinned        = probes[i].typed;
      pinned_report = '{probes[i].ecc, probes[i].st, probes[i].err_byte, probes[i].err_bit};
      send_byte(probes[i].data, probes[i].stored);
    end
    pinned = 1'b0;

    // Random phases. Phase 0 carries the long receiver hold, phase 1 runs
    // with no idling at all, phase 3 pauses half way until every report is
    // in, and two phases run the largest stripe, once through an oversized
    // register value.
    phase = 0;
    while (bytes_taken < BYTE_TARGET) begin
      case (phase)
        0, 3:    reg_val = 0;
        2:       reg_val = SIZE_BOUND;
        5:       reg_val = $urandom_range(SIZE_BOUND + 1, 15);
        default: reg_val = $urandom_range(0, 6);
      endcase
      write_size(reg_val);
      calm = (phase == 1);
      if (phase == 0) hold_now = 1'b1;
      lg      = (reg_val > SIZE_BOUND) ? SIZE_BOUND : reg_val;
      stripes = (lg >= SIZE_BOUND || (48 >> lg) == 0) ? 1 : (48 >> lg);
      for (s = 0; s < stripes; s++) begin
        if (phase == 3 && s == stripes / 2) begin
          in_valid <= 1'b0;
          while (due_reports.size() != 0) @(negedge clk);
        end
        send_stripe(lg);
      end
      phase++;
    end
    calm = 1'b0;

    // Let every report come home, then wait a while for stray ones.
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0 && due_reports.size() == 0)
      $display("nand_hamming_ecc_check_top regression: pass");
    else
      $display("nand_hamming_ecc_check_top regression: fail");
    $finish;
  end

endmodule
